FILE: src/response_frame_checker_defines.svh
// Assertion macros shared by the response frame checker RTL.
`ifndef RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define RESPONSE_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfc assertion failed");

`endif

FILE: src/rfc_pkg.sv
`timescale 1ns / 1ps
package rfc_pkg;

  // Closing status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PREAMBLE = 3'd1;
  localparam logic [2:0] ST_LCS      = 3'd2;
  localparam logic [2:0] ST_TFI      = 3'd3;
  localparam logic [2:0] ST_CODE     = 3'd4;
  localparam logic [2:0] ST_DCS      = 3'd5;
  localparam logic [2:0] ST_POST     = 3'd6;
  localparam logic [2:0] ST_LENGTH   = 3'd7;

  // Configuration register indexes
  localparam logic CFG_EXPECTED_CODE   = 1'b0;
  localparam logic CFG_MAX_PAYLOAD_LEN = 1'b1;

  localparam logic [7:0]  EXPECTED_CODE_RST   = 8'h00;
  localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'd255;

  // One result transaction
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_payload;
    logic        is_final;
    logic [2:0]  status;
    logic [15:0] payload_len;
  } rfc_result_t;

endpackage

FILE: src/rfc_parser.sv
`timescale 1ns / 1ps
`include "response_frame_checker_defines.svh"
module rfc_parser
  import rfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [7:0]  expected_code,
  input  logic [15:0] max_payload_len,
  output logic        res_valid,
  output rfc_result_t res
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_PRE0   = 4'd1;
  localparam logic [3:0] PH_PRE1   = 4'd2;
  localparam logic [3:0] PH_PRE2   = 4'd3;
  localparam logic [3:0] PH_LEN    = 4'd4;
  localparam logic [3:0] PH_LCS    = 4'd5;
  localparam logic [3:0] PH_EXTHI  = 4'd6;
  localparam logic [3:0] PH_EXTLO  = 4'd7;
  localparam logic [3:0] PH_EXTLCS = 4'd8;
  localparam logic [3:0] PH_TFI    = 4'd9;
  localparam logic [3:0] PH_CODE   = 4'd10;
  localparam logic [3:0] PH_DATA   = 4'd11;
  localparam logic [3:0] PH_DCS    = 4'd12;
  localparam logic [3:0] PH_POST   = 4'd13;

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  length_high_r, length_high_nxt;

  // State as seen by this byte: a first flag restarts the frame
  logic [3:0]  ph;
  logic [15:0] fl, bc, bc_inc, data_len;
  logic [7:0]  rs, lh, sum8;
  logic        len_bad;

  assign ph       = first_byte ? PH_PRE0 : phase_r;
  assign fl       = first_byte ? 16'd0 : frame_len_r;
  assign bc       = first_byte ? 16'd0 : byte_count_r;
  assign rs       = first_byte ? 8'd0 : running_sum_r;
  assign lh       = first_byte ? 8'd0 : length_high_r;
  assign sum8     = rs + data_byte;
  assign bc_inc   = bc + 16'd1;
  assign data_len = fl - 16'd2;
  assign len_bad  = (fl < 16'd2) || (data_len > max_payload_len);

  always_comb begin
    phase_nxt       = ph;
    frame_len_nxt   = fl;
    byte_count_nxt  = bc;
    running_sum_nxt = rs;
    length_high_nxt = lh;
    res_valid       = 1'b0;
    res             = '0;
    res.payload_len = bc;
    case (ph)
      PH_PRE0: begin
        if (data_byte != 8'h00) begin
          res_valid = 1'b1; res.is_final = 1'b1; res.status = ST_PREAMBLE;
        end else begin
          phase_nxt = PH_PRE1;
        end
      end
      PH_PRE1: begin
        if (data_byte != 8'h00) begin
          res_valid = 1'b1; res.is_final = 1'b1; res.status = ST_PREAMBLE;
        end else begin
          phase_nxt = PH_PRE2;
        end
      end
      PH_PRE2: begin
        if (data_byte != 8'hFF) begin
          res_valid = 1'b1; res.is_final = 1'b1; res.status = ST_PREAMBLE;
        end else begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        frame_len_nxt = {8'h00, data_byte};
        phase_nxt     = PH_LCS;
      end
      PH_LCS: begin
        if (fl == 16'h00FF && data_byte == 8'hFF) begin
          phase_nxt = PH_EXTHI;
        end else if ((fl[7:0] + data_byte) != 8'h00) begin
          res_valid = 1'b1; res.is_final = 1'b1; res.status = ST_LCS;
        end else if (len_bad) begin
          res_valid = 1'b1; res.is_final = 1'b1; res.status = ST_LENGTH;
        end else begin
          phase_nxt = PH_TFI;
        end
      end
      PH_EXTHI: begin
        length_high_nxt = data_byte;
        running_sum_nxt = data_byte;
        phase_nxt       = PH_EXTLO;
      end
      PH_EXTLO: begin
        frame_len_nxt   = {lh, data_byte};
        running_sum_nxt = sum8;
        phase_nxt       = PH_EXTLCS;
      end
      PH_EXTLCS: begin
        if (sum8 != 8'h00) begin
          res_valid = 1'b1; res.is_final = 1'b1; res.status = ST_LCS;
        end else if (len_bad) begin
          res_valid = 1'b1; res.is_final = 1'b1; res.status = ST_LENGTH;
        end else begin
          phase_nxt = PH_TFI;
        end
      end
      PH_TFI: begin
        if (data_byte != 8'hD5) begin
          res_valid = 1'b1; res.is_final = 1'b1; res.status = ST_TFI;
        end else begin
          running_sum_nxt = data_byte;
          phase_nxt       = PH_CODE;
        end
      end
      PH_CODE: begin
        if (data_byte != expected_code) begin
          res_valid = 1'b1; res.is_final = 1'b1; res.status = ST_CODE;
        end else begin
          running_sum_nxt = sum8;
          byte_count_nxt  = 16'd0;
          phase_nxt       = (fl == 16'd2) ? PH_DCS : PH_DATA;
        end
      end
      PH_DATA: begin
        running_sum_nxt  = sum8;
        byte_count_nxt   = bc_inc;
        if (bc_inc == data_len) phase_nxt = PH_DCS;
        res_valid        = 1'b1;
        res.payload_byte = data_byte;
        res.is_payload   = 1'b1;
        res.payload_len  = 16'd0;
      end
      PH_DCS: begin
        if (sum8 != 8'h00) begin
          res_valid = 1'b1; res.is_final = 1'b1; res.status = ST_DCS;
        end else begin
          phase_nxt = PH_POST;
        end
      end
      PH_POST: begin
        res_valid    = 1'b1;
        res.is_final = 1'b1;
        res.status   = (data_byte != 8'h00) ? ST_POST : ST_OK;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    // Every closing result drops back to idle
    if (res.is_final) phase_nxt = PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      frame_len_r   <= 16'd0;
      byte_count_r  <= 16'd0;
      running_sum_r <= 8'd0;
      length_high_r <= 8'd0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      frame_len_r   <= frame_len_nxt;
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
      length_high_r <= length_high_nxt;
    end
  end

  `RFC_ASSERT_NXT(a_final_to_idle, clk, rst_n, accept && res_valid && res.is_final, phase_r == PH_IDLE)
  `RFC_ASSERT_IMP(a_kind_exclusive, clk, rst_n, res_valid, res.is_payload != res.is_final)
  `RFC_ASSERT_IMP(a_idle_silent, clk, rst_n, !first_byte && phase_r == PH_IDLE, !res_valid)

endmodule

FILE: src/rfc_outbuf.sv
`timescale 1ns / 1ps
`include "response_frame_checker_defines.svh"
module rfc_outbuf
  import rfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rfc_result_t push_data,
  output logic        can_push,
  output logic        out_valid,
  input  logic        out_ready,
  output rfc_result_t out_data
);

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  rfc_result_t out_data_r, out_data_nxt;
  rfc_result_t skid_data_r, skid_data_nxt;
  logic        take;

  assign take      = out_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (push) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (take) begin
      // Advance the skid entry, if any, into the output register
      out_valid_nxt  = skid_valid_r;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `RFC_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `RFC_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !skid_valid_r)
  `RFC_ASSERT_NXT(a_stall_fills_skid, clk, rst_n, push && out_valid_r && !out_ready, skid_valid_r)

endmodule

FILE: src/response_frame_checker.sv
`timescale 1ns / 1ps
// Each result transaction is registered in the output buffer before it is offered on out_*.
// Throughput: one byte per cycle while in_ready is high; the per-byte phase update is a single registered step.
// A two-entry output buffer (output register plus skid) keeps in_ready high during one
// output stall; in_ready drops only once both entries hold results.
// Reset (rst_n low, synchronous): parser goes idle, buffers empty, registers take defaults.
module response_frame_checker
  import rfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // received byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  // result stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_payload,
  output logic        out_is_final,
  output logic [2:0]  out_status,
  output logic [15:0] out_payload_len,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [7:0]  expected_code_r;
  logic [15:0] max_payload_len_r;
  logic        accept;
  logic        res_valid;
  logic        can_push;
  rfc_result_t res;
  rfc_result_t out_data;

  // Configuration registers: write on cfg_we, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_code_r   <= EXPECTED_CODE_RST;
      max_payload_len_r <= MAX_PAYLOAD_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_CODE:   expected_code_r   <= cfg_wdata[7:0];
        CFG_MAX_PAYLOAD_LEN: max_payload_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accept a byte whenever the output buffer has a free entry; every byte
  // yields at most one result, so one free entry is always enough.
  assign in_ready = can_push;
  assign accept   = in_valid && in_ready;

  // Frame phase tracking, checksums and length checks.
  rfc_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .first_byte      (in_first_byte),
    .expected_code   (expected_code_r),
    .max_payload_len (max_payload_len_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Result register with skid entry; push only on an accepted byte that
  // produced a result.
  rfc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_payload_byte = out_data.payload_byte;
  assign out_is_payload   = out_data.is_payload;
  assign out_is_final     = out_data.is_final;
  assign out_status       = out_data.status;
  assign out_payload_len  = out_data.payload_len;

endmodule
